[src/fbpa_pkg.sv]
package fbpa_pkg;

    localparam int FREE_STACK_DEPTH = 4096;
    localparam int FS_AW            = $clog2(FREE_STACK_DEPTH);
    localparam int FC_W             = FS_AW + 1;
    localparam int MAX_CHUNKS       = 64;
    localparam int CT_AW            = $clog2(MAX_CHUNKS);
    localparam int CC_W             = CT_AW + 1;
    localparam int ADDR_BITS        = 32;

    localparam int OBJ_W   = 17;
    localparam int CHUNK_W = 21;
    localparam int ARENA_W = 31;
    localparam int BLK_W   = 18;
    localparam int CFG_IW  = 8;
    localparam int CFG_DW  = 32;

    // Divider operands are in units of 64 bytes.
    localparam int DIVD_W = CHUNK_W - 6;
    localparam int DIVS_W = BLK_W - 6;

    localparam logic [OBJ_W-1:0]   OBJ_RST   = 17'd64;
    localparam logic [CHUNK_W-1:0] CHUNK_RST = 21'd65536;
    localparam logic [ARENA_W-1:0] ARENA_RST = 31'd419430400;
    localparam logic [31:0]        BASE_RST  = 32'd268435456;
    localparam logic [CHUNK_W-1:0] TAIL_BYTES = 21'd64;

    typedef enum logic [CFG_IW-1:0] {
        REG_OBJECT_BYTES = 8'd0,
        REG_CHUNK_BYTES  = 8'd1,
        REG_ARENA_BYTES  = 8'd2,
        REG_ARENA_BASE   = 8'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OOM       = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_DROPPED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_STACK = 2'd1,
        SRC_HOLD  = 2'd2,
        SRC_ADDR  = 2'd3
    } src_t;

    typedef struct packed {
        logic    load_in;
        logic    pop;
        logic    push;
        logic    scan_clr;
        logic    scan_inc;
        logic    ct_rd;
        logic    div_start;
        logic    div_free;
        logic    grow_commit;
        logic    alloc_fresh;
        logic    out_load;
        status_t out_status;
        src_t    out_src;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic addr_zero;
        logic stack_empty;
        logic stack_full;
        logic fresh_empty;
        logic too_large;
        logic oom;
        logic scan_end;
        logic hit_cand;
        logic div_done;
        logic rem_zero;
    } dp_stat_t;

endpackage

[src/fbpa_div.sv]
module fbpa_div
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quot,
    output logic [DIVS_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] q_reg, q_next;
    logic [DIVS_W-1:0] r_reg, r_next;
    logic [DIVS_W-1:0] d_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic              fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {r_reg, q_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIVD_W-2:0], fits};
            r_next   = fits ? DIVS_W'(trial - {1'b0, d_reg}) : trial[DIVS_W-1:0];
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

[src/fbpa_datapath.sv]
module fbpa_datapath
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_idx,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_cmd,
    input  logic [31:0]       in_addr,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic [2:0]        out_status,
    output logic [31:0]       out_addr
);

    logic [OBJ_W-1:0]   obj_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [ARENA_W-1:0] arena_bytes_reg;
    logic [31:0]        base_reg;

    logic               cmd_reg;
    logic [31:0]        addr_reg;
    logic [FC_W-1:0]    freed_count_reg;
    logic [CC_W-1:0]    chunk_count_reg;
    logic [CC_W-1:0]    scan_reg;
    logic [31:0]        fresh_next_reg;
    logic [DIVD_W-1:0]  fresh_left_reg;
    logic [ARENA_W-1:0] arena_off_reg;
    logic [31:0]        hold_reg;

    logic [31:0] stack_mem [FREE_STACK_DEPTH];
    logic [31:0] chunk_mem [MAX_CHUNKS];
    logic [31:0] stack_q;
    logic [31:0] chunk_q;

    logic [OBJ_W-1:0]   obj1;
    logic [BLK_W-1:0]   blk;
    logic [CHUNK_W-1:0] usable;
    logic [31:0]        off;
    logic [31:0]        start_addr;
    logic [ARENA_W:0]   arena_end;
    logic [FC_W-1:0]    pop_ptr;
    logic [DIVD_W-1:0]  div_a;
    logic               div_done;
    logic [DIVD_W-1:0]  div_q;
    logic [DIVS_W-1:0]  div_r;

    // Block size is the object size rounded up to 64 bytes, zero treated as one.
    assign obj1   = (obj_reg == '0) ? OBJ_W'(1) : obj_reg;
    assign blk    = (BLK_W'(obj1) + BLK_W'(63)) & ~BLK_W'(63);
    assign usable = (chunk_reg > TAIL_BYTES) ? CHUNK_W'(chunk_reg - TAIL_BYTES) : '0;

    assign off        = addr_reg - chunk_q;
    assign start_addr = base_reg + {1'b0, arena_off_reg};
    assign arena_end  = {1'b0, arena_off_reg} + (ARENA_W+1)'(chunk_reg);
    assign pop_ptr    = FC_W'(freed_count_reg - 1'b1);

    assign div_a = cmd.div_free ? off[CHUNK_W-1:6] : usable[CHUNK_W-1:6];

    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (blk[BLK_W-1:6]),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        stat.is_free     = cmd_reg;
        stat.addr_zero   = addr_reg == '0;
        stat.stack_empty = freed_count_reg == '0;
        stat.stack_full  = freed_count_reg >= FC_W'(FREE_STACK_DEPTH);
        stat.fresh_empty = fresh_left_reg == '0;
        stat.too_large   = {3'b0, blk} > usable;
        stat.oom         = (chunk_count_reg >= CC_W'(MAX_CHUNKS))
                        || (arena_end > {1'b0, arena_bytes_reg});
        stat.scan_end    = scan_reg >= chunk_count_reg;
        stat.hit_cand    = (addr_reg >= chunk_q) && (off < 32'(usable))
                        && (off[5:0] == '0);
        stat.div_done    = div_done;
        stat.rem_zero    = div_r == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_reg         <= OBJ_RST;
            chunk_reg       <= CHUNK_RST;
            arena_bytes_reg <= ARENA_RST;
            base_reg        <= BASE_RST;
            freed_count_reg <= '0;
            chunk_count_reg <= '0;
            scan_reg        <= '0;
            fresh_next_reg  <= '0;
            fresh_left_reg  <= '0;
            arena_off_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_OBJECT_BYTES: obj_reg         <= cfg_data[OBJ_W-1:0];
                    REG_CHUNK_BYTES:  chunk_reg       <= cfg_data[CHUNK_W-1:0];
                    REG_ARENA_BYTES:  arena_bytes_reg <= cfg_data[ARENA_W-1:0];
                    REG_ARENA_BASE:   base_reg        <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.pop)
            begin
                freed_count_reg <= pop_ptr;
            end
            else if (cmd.push)
            begin
                freed_count_reg <= FC_W'(freed_count_reg + 1'b1);
            end
            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= CC_W'(scan_reg + 1'b1);
            end
            if (cmd.grow_commit)
            begin
                chunk_count_reg <= CC_W'(chunk_count_reg + 1'b1);
                arena_off_reg   <= arena_end[ARENA_W-1:0];
                fresh_next_reg  <= start_addr;
                fresh_left_reg  <= div_q;
            end
            else if (cmd.alloc_fresh)
            begin
                fresh_next_reg <= fresh_next_reg + 32'(blk);
                fresh_left_reg <= DIVD_W'(fresh_left_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg  <= in_cmd;
            addr_reg <= in_addr;
        end
        if (cmd.alloc_fresh)
        begin
            hold_reg <= fresh_next_reg;
        end
        if (cmd.pop)
        begin
            stack_q <= stack_mem[pop_ptr[FS_AW-1:0]];
        end
        if (cmd.push)
        begin
            stack_mem[freed_count_reg[FS_AW-1:0]] <= addr_reg;
        end
        if (cmd.ct_rd)
        begin
            chunk_q <= chunk_mem[scan_reg[CT_AW-1:0]];
        end
        if (cmd.grow_commit)
        begin
            chunk_mem[chunk_count_reg[CT_AW-1:0]] <= start_addr;
        end
        if (cmd.out_load)
        begin
            out_status <= cmd.out_status;
            unique case (cmd.out_src)
                SRC_ZERO:  out_addr <= '0;
                SRC_STACK: out_addr <= stack_q;
                SRC_HOLD:  out_addr <= hold_reg;
                SRC_ADDR:  out_addr <= addr_reg;
                default:   out_addr <= '0;
            endcase
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> freed_count_reg != '0)
        else $error("pop from empty free stack");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> freed_count_reg < FC_W'(FREE_STACK_DEPTH))
        else $error("push onto full free stack");

    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grow_commit |-> chunk_count_reg < CC_W'(MAX_CHUNKS))
        else $error("chunk table overflow");

    a_grow_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grow_commit |-> div_q != '0)
        else $error("new chunk holds no block");

endmodule

[src/fbpa_ctrl.sv]
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_GROW_DIV = 8'b0000_0100,
        S_ALLOC    = 8'b0000_1000,
        S_FREE_RD  = 8'b0001_0000,
        S_FREE_CHK = 8'b0010_0000,
        S_FREE_DIV = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    src_t    src_reg, src_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.out_status = st_reg;
        cmd.out_src    = src_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_free)
                begin
                    src_next = SRC_ADDR;
                    if (stat.addr_zero)
                    begin
                        st_next    = ST_IGNORED;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_FREE_RD;
                    end
                end
                else if (!stat.stack_empty)
                begin
                    cmd.pop    = 1'b1;
                    st_next    = ST_OK;
                    src_next   = SRC_STACK;
                    state_next = S_FINISH;
                end
                else if (!stat.fresh_empty)
                begin
                    state_next = S_ALLOC;
                end
                else if (stat.too_large)
                begin
                    st_next    = ST_TOO_LARGE;
                    src_next   = SRC_ZERO;
                    state_next = S_FINISH;
                end
                else if (stat.oom)
                begin
                    st_next    = ST_OOM;
                    src_next   = SRC_ZERO;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_GROW_DIV;
                end
            end
            S_GROW_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.grow_commit = 1'b1;
                    state_next      = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_fresh = 1'b1;
                st_next         = ST_OK;
                src_next        = SRC_HOLD;
                state_next      = S_FINISH;
            end
            S_FREE_RD:
            begin
                if (stat.scan_end)
                begin
                    st_next    = ST_IGNORED;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.ct_rd  = 1'b1;
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                if (stat.hit_cand)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_free  = 1'b1;
                    state_next    = S_FREE_DIV;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_FREE_RD;
                end
            end
            S_FREE_DIV:
            begin
                if (stat.div_done)
                begin
                    if (!stat.rem_zero)
                    begin
                        cmd.scan_inc = 1'b1;
                        state_next   = S_FREE_RD;
                    end
                    else if (stat.stack_full)
                    begin
                        st_next    = ST_DROPPED;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        st_next    = ST_OK;
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_OK;
            src_reg       <= SRC_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result register overwritten");

    a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded word not presented");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_DISPATCH)
        else $error("accepted word not dispatched");

endmodule

[src/fixed_block_pool_allocator.sv]
// Fixed-size block pool allocator.
// Requests arrive on the s_* stream: s_tuser is the command (0 allocate,
// 1 free) and s_tdata the address to free. Each request yields exactly one
// result word on the m_* stream: m_tuser carries the status code and m_tdata
// the allocated address, zero on a failed allocate, or the echoed address of
// a free. Object size (and so block size), chunk size, arena size and arena
// base are set on the cfg_* write port, by the user only while no request is
// in progress; the block itself does not enforce this. One request is
// processed at a time. A pop from the free stack or an allocate from the
// current chunk finishes without the divider. Growing by a new chunk runs the
// shared divider. A free scans the chunk table entry by entry and runs the
// divider for each chunk whose range and 64-byte alignment match, until one
// leaves no remainder.
// Reset restores the register defaults and empties the free stack and chunk
// table; no clearing pass is needed. The result sits in an output register,
// so a stalled receiver holds m_tvalid and the next request can be accepted
// and worked on until it, too, needs that register.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_idx,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] addr
    input  logic              s_tuser,   // [0] cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] block_addr
    output logic [2:0]        m_tuser    // [2:0] status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller sequences each request; the datapath holds the pool state.
    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbpa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .in_cmd     (s_tuser),
        .in_addr    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (m_tuser),
        .out_addr   (m_tdata)
    );

endmodule

[dv/fixed_block_pool_allocator_tb.sv]
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    localparam longint unsigned ADDR_MASK = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 200;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ALLOC,
        ROW_FREE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  reg_idx;
        logic [31:0] value;     // register data or the address to free
        bit          typed;     // expected word written into the row
        status_t     exp_status;
        logic [31:0] exp_addr;
    } row_t;

    typedef struct {
        status_t     status;
        logic [31:0] addr;
    } result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_idx;
    logic [CFG_DW-1:0] cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [31:0] addr
    logic              s_tuser;   // [0] cmd
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // [31:0] block_addr
    logic [2:0]        m_tuser;   // [2:0] status

    fixed_block_pool_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The shadow copy of the allocator: registers and pool state.
    longint unsigned obj_bytes;
    longint unsigned chunk_sz;
    longint unsigned arena_sz;
    longint unsigned arena_start;
    longint unsigned free_lifo [FREE_STACK_DEPTH];
    int              free_depth;
    longint unsigned chunk_start [MAX_CHUNKS];
    int              chunks_owned;
    longint unsigned next_slot;
    longint unsigned slots_left;
    longint unsigned arena_used;

    result_t     pending_results[$];
    logic [31:0] live_blocks[$];   // recently handed out addresses, used to build frees
    row_t        directed_rows[$];
    int          errors = 0;
    int          cycles = 0;
    bit          rx_no_stall;      // lets the receiver run flat out in some phases
    int          rx_stall_left;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // A global watchdog: a hung block or a lost word ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: stalls of random length, mostly short, now and then long.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready      <= 1'b0;
            rx_stall_left <= 0;
        end else if (rx_no_stall) begin
            m_tready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) begin
                rx_stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    // Every word leaving the block is compared with the oldest expected word.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word status=%0d addr=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_tuser);
                    errors++;
                end
                if (m_tdata !== want.addr) begin
                    $display("%0t: block_addr expected %h actual %h", $time, want.addr,
                             m_tdata);
                    errors++;
                end
            end
        end
    end

    // Appends one expected word to the scoreboard.
    function automatic void expect_result(result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Keeps a window of the most recently handed out addresses.
    function automatic void remember_block(logic [31:0] a);
        live_blocks.insert(live_blocks.size(), a);
        if (live_blocks.size() > 64) begin
            void'(live_blocks.pop_front());
        end
    endfunction

    // Computes the word the allocator must return for one request and updates
    // the shadow pool exactly as the block would.
    function automatic result_t serve_request(bit is_free, logic [31:0] a);
        result_t         r;
        longint unsigned obj;
        longint unsigned blk;
        longint unsigned usable;
        longint unsigned c;
        longint unsigned addr;
        bit              owned;
        addr     = 64'(a);
        obj      = (obj_bytes == 0) ? 1 : obj_bytes;
        blk      = (obj + 63) & ~64'd63;
        usable   = (chunk_sz > 64) ? chunk_sz - 64 : 0;
        r.status = ST_OK;
        r.addr   = '0;
        if (!is_free) begin
            if (free_depth > 0) begin
                free_depth--;
                r.addr = 32'(free_lifo[free_depth]);
            end else begin
                if (slots_left == 0) begin
                    // Growth: the size check comes ahead of the two out-of-memory checks.
                    if (blk > usable) begin
                        r.status = ST_TOO_LARGE;
                    end else if (chunks_owned >= MAX_CHUNKS ||
                                 arena_used + chunk_sz > arena_sz) begin
                        r.status = ST_OOM;
                    end else begin
                        c = (arena_start + arena_used) & ADDR_MASK;
                        arena_used += chunk_sz;
                        chunk_start[chunks_owned] = c;
                        chunks_owned++;
                        next_slot  = c;
                        slots_left = usable / blk;
                    end
                end
                if (r.status == ST_OK) begin
                    r.addr = 32'(next_slot);
                    next_slot  = (next_slot + blk) & ADDR_MASK;
                    slots_left = slots_left - 1;
                end
            end
            if (r.status == ST_OK) begin
                remember_block(r.addr);
            end
        end else begin
            r.addr = a;
            owned  = 1'b0;
            // The range test is done without wrap, against the current registers.
            if (addr != 0) begin
                for (int i = 0; i < chunks_owned; i++) begin
                    c = chunk_start[i];
                    if (addr >= c && addr < c + chunk_sz &&
                        (addr - c) % blk == 0 && (addr - c) < usable) begin
                        owned = 1'b1;
                    end
                end
            end
            if (!owned) begin
                r.status = ST_IGNORED;
            end else if (free_depth >= FREE_STACK_DEPTH) begin
                r.status = ST_DROPPED;
            end else begin
                free_lifo[free_depth] = addr;
                free_depth++;
            end
        end
        return r;
    endfunction

    // Sends one request word with a random gap ahead of it. On return the word
    // has been accepted and s_tvalid is still high.
    task automatic send_request(bit is_free, logic [31:0] a, bit typed = 1'b0,
                                status_t t_status = ST_OK, logic [31:0] t_addr = '0);
        int      gap;
        result_t r;
        gap = 0;
        if ($urandom_range(0, 99) < 35) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_free;
        s_tdata  <= a;
        do begin
            @(posedge clk);
        end while (!s_tready);
        r = serve_request(is_free, a);
        if (typed) begin
            r.status = t_status;
            r.addr   = t_addr;
        end
        expect_result(r);
    endtask

    // Lowers s_tvalid and waits until every expected word has come back, so
    // the block is idle and registers may be written.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_OBJECT_BYTES: obj_bytes   = 64'(data & 32'h1_FFFF);
            REG_CHUNK_BYTES:  chunk_sz    = 64'(data & 32'h1F_FFFF);
            REG_ARENA_BYTES:  arena_sz    = 64'(data & 32'h7FFF_FFFF);
            REG_ARENA_BASE:   arena_start = 64'(data);
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random register setting for one phase. Arena size is kept zero to six chunks
    // above what has been used, now and then the maximum, so growth and out-of-memory both show up.
    task automatic random_settings();
        longint unsigned ob;
        longint unsigned cb;
        longint unsigned ab;
        longint unsigned bs;
        case ($urandom_range(0, 9))
            0:       ob = 0;
            1:       ob = 32'h1_FFFF;
            2:       ob = $urandom_range(1, 65536);
            default: ob = $urandom_range(1, 256);
        endcase
        case ($urandom_range(0, 11))
            0:       cb = $urandom_range(0, 64);
            1:       cb = 32'h1F_FFFF;
            2:       cb = $urandom_range(128, 1048576);
            default: cb = $urandom_range(128, 2048);
        endcase
        ab = arena_used + cb * $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0 || ab > 64'h7FFF_FFFF) begin
            ab = 64'h7FFF_FFFF;
        end
        case ($urandom_range(0, 7))
            0:       bs = 32'hFFFF_F000;
            1:       bs = $urandom();
            default: bs = $urandom_range(1, 32'hC000_0000) & ~32'd63;
        endcase
        write_reg(REG_OBJECT_BYTES, 32'(ob));
        write_reg(REG_CHUNK_BYTES, 32'(cb));
        write_reg(REG_ARENA_BYTES, 32'(ab));
        write_reg(REG_ARENA_BASE, 32'(bs));
        end_writes();
    endtask

    // A free aimed at the pool most of the time: an address handed out
    // earlier, one nudged off it, or something arbitrary.
    function automatic logic [31:0] pick_free_addr();
        logic [31:0] a;
        if (live_blocks.size() == 0 || $urandom_range(0, 99) < 15) begin
            a = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
        end else begin
            a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            case ($urandom_range(0, 9))
                0: a = a + $urandom_range(1, 63);
                1: a = a + 64 * $urandom_range(1, 40);
                2: a = a - 64;
                default: ;
            endcase
        end
        return a;
    endfunction

    task automatic add_row(row_kind_t kind, logic [31:0] value, logic [7:0] idx = '0,
                           bit typed = 1'b0, status_t st = ST_OK, logic [31:0] ea = '0);
        row_t r;
        r.kind       = kind;
        r.reg_idx    = idx;
        r.value      = value;
        r.typed      = typed;
        r.exp_status = st;
        r.exp_addr   = ea;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    initial begin
        int          phase_items;
        bit          in_cfg;

        rx_no_stall = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;

        obj_bytes    = 64'(OBJ_RST);
        chunk_sz     = 64'(CHUNK_RST);
        arena_sz     = 64'(ARENA_RST);
        arena_start  = 64'(BASE_RST);
        free_depth   = 0;
        chunks_owned = 0;
        next_slot    = 0;
        slots_left   = 0;
        arena_used   = 0;

        // Directed table. The first setting puts the arena at address zero with
        // the smallest chunk that holds a block, so one slot per chunk and two chunks in all.
        add_row(ROW_CFG, 0, REG_OBJECT_BYTES);
        add_row(ROW_CFG, 128, REG_CHUNK_BYTES);
        add_row(ROW_CFG, 256, REG_ARENA_BYTES);
        add_row(ROW_CFG, 0, REG_ARENA_BASE);
        add_row(ROW_ALLOC, 0, 0, 1, ST_OK, 32'h0);
        add_row(ROW_FREE, 32'h0, 0, 1, ST_IGNORED, 32'h0);          // block at zero
        add_row(ROW_ALLOC, 0, 0, 1, ST_OK, 32'h80);
        add_row(ROW_ALLOC, 0, 0, 1, ST_OOM, 32'h0);                 // arena used up
        add_row(ROW_FREE, 32'h80, 0, 1, ST_OK, 32'h80);
        add_row(ROW_FREE, 32'hC0, 0, 1, ST_IGNORED, 32'hC0);        // chunk tail
        add_row(ROW_FREE, 32'h81, 0, 1, ST_IGNORED, 32'h81);        // misaligned
        add_row(ROW_FREE, 32'hFFFF_FFFF, 0, 1, ST_IGNORED, 32'hFFFF_FFFF);
        add_row(ROW_ALLOC, 0, 0, 1, ST_OK, 32'h80);                 // pop from the stack
        add_row(ROW_CFG, 64, REG_CHUNK_BYTES);                      // no usable bytes
        add_row(ROW_ALLOC, 0, 0, 1, ST_TOO_LARGE, 32'h0);
        add_row(ROW_CFG, 128, REG_CHUNK_BYTES);
        add_row(ROW_CFG, 32'h1_FFFF, REG_OBJECT_BYTES);
        add_row(ROW_ALLOC, 0, 0, 1, ST_TOO_LARGE, 32'h0);
        // A chunk that straddles the top of the address space.
        add_row(ROW_CFG, 64, REG_OBJECT_BYTES);
        add_row(ROW_CFG, 256, REG_CHUNK_BYTES);
        add_row(ROW_CFG, 32'h7FFF_FFFF, REG_ARENA_BYTES);
        add_row(ROW_CFG, 32'hFFFF_FE80, REG_ARENA_BASE);
        add_row(ROW_CFG, 32'hDEAD_BEEF, 8'd7);                      // no such register
        add_row(ROW_ALLOC, 0, 0, 1, ST_OK, 32'hFFFF_FF80);
        add_row(ROW_ALLOC, 0, 0, 1, ST_OK, 32'hFFFF_FFC0);
        add_row(ROW_ALLOC, 0, 0, 1, ST_OK, 32'h0);                  // wrapped slot
        add_row(ROW_FREE, 32'hFFFF_FFC0, 0, 1, ST_OK, 32'hFFFF_FFC0);
        add_row(ROW_FREE, 32'h0, 0, 1, ST_IGNORED, 32'h0);
        add_row(ROW_ALLOC, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_cfg = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (!in_cfg) begin
                    wait_idle();
                    in_cfg = 1'b1;
                end
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                if (in_cfg) begin
                    end_writes();
                    in_cfg = 1'b0;
                end
                send_request(directed_rows[i].kind == ROW_FREE, directed_rows[i].value,
                             directed_rows[i].typed, directed_rows[i].exp_status,
                             directed_rows[i].exp_addr);
            end
        end

        // Random phases: a fresh register setting each, then a mix that is
        // mostly alloc/free traffic on the live pool.
        for (int phase = 0; phase < 9; phase++) begin
            wait_idle();
            random_settings();
            rx_no_stall = (phase % 3 == 2);
            phase_items = 50;
            for (int n = 0; n < phase_items; n++) begin
                if (phase == 4 && n == 25) begin
                    // Sender holds off until the block has drained.
                    wait_idle();
                end
                if ($urandom_range(0, 99) < 55) begin
                    send_request(1'b0, $urandom());
                end else begin
                    send_request(1'b1, pick_free_addr());
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
